[hw/rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, operation and status codes, and the entry and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OCC_W    = 5;
  localparam int STATUS_W = 2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } spq_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_if.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready interfaces for the request and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface spq_in_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [DATA_W-1:0] item_value;
  logic signed [DATA_W-1:0] item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink   (input valid, operation, item_value, item_priority, output ready);
endinterface

interface spq_out_if;
  import spq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] removed_value;
  logic signed [DATA_W-1:0] removed_priority;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, status, removed_value, removed_priority, occupancy,
                  input ready);
  modport sink   (input valid, status, removed_value, removed_priority, occupancy,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue
// A bounded priority queue held as a row of cells sorted by priority.
// ----------------------------------------------------------------------------
// Each beat on in_ch is an insert (value and priority) or a remove. Every
// request produces exactly one result beat on out_ch carrying a status, the
// removed entry (zero unless a remove succeeded) and the occupancy after
// the request. The lowest priority number leaves first; equal priorities
// leave in arrival order. A remove from an empty queue reports underflow and
// an insert into a full queue is dropped and reports full.
// Every cell compares its priority against the request in parallel and
// shifts left or right by one place on the accepting clock edge, so
// the result appears in the output register the cycle after acceptance and
// one request per cycle is sustained while the receiver takes results.
// in_ch.ready is high whenever the output register is empty or its beat is
// being taken, so a stalled receiver holds the result and blocks only the
// next request. Reset empties the queue and clears the output valid flag; no
// clearing pass over the cells is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  spq_in_if.sink    in_ch,
  spq_out_if.source out_ch
);
  import spq_pkg::*;

  logic [CNT_W-1:0]    count_r;
  logic [CNT_W-1:0]    count_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [STATUS_W-1:0] status_nxt;
  logic [DATA_W-1:0]   rval_r;
  logic [DATA_W-1:0]   rval_nxt;
  logic [DATA_W-1:0]   rprio_r;
  logic [DATA_W-1:0]   rprio_nxt;

  logic     accept;
  logic     full;
  logic     empty;
  spq_ctl_t ctl;
  entry_t   new_entry;
  entry_t   cell_entry [CAPACITY];
  logic     cell_keep  [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign empty       = (count_r == '0);
  assign ctl.ins     = accept && (in_ch.operation == OP_INSERT) && !full;
  assign ctl.rem     = accept && (in_ch.operation == OP_REMOVE) && !empty;
  assign new_entry   = '{value: in_ch.item_value, prio: in_ch.item_priority};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_keep;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_mid
      assign left_keep  = cell_keep[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .own_valid   (count_r > CNT_W'(i)),
      .new_entry   (new_entry),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .keep        (cell_keep[i]),
      .entry       (cell_entry[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STATUS_OK;
    rval_nxt   = '0;
    rprio_nxt  = '0;
    if (in_ch.operation == OP_INSERT) begin
      if (full) begin
        status_nxt = STATUS_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_nxt = STATUS_UNDERFLOW;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        rval_nxt  = cell_entry[0].value;
        rprio_nxt = cell_entry[0].prio;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rval_r   <= rval_nxt;
      rprio_r  <= rprio_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.removed_value    = rval_r;
  assign out_ch.removed_priority = rprio_r;
  assign out_ch.occupancy        = OCC_W'(count_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("queue count exceeds capacity");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (in_ch.operation == OP_INSERT)) |=> $stable(count_r))
    else $error("dropped insert changed the count");

  a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == STATUS_UNDERFLOW)) |-> (rval_r == '0 && count_r == '0))
    else $error("underflow result carries data or a nonzero count");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(status_r)))
    else $error("stalled result was lost");
`endif

endmodule

`default_nettype wire

[hw/rtl/spq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbour's entry, and on remove it takes its right neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic             clk,
  input  wire spq_pkg::spq_ctl_t ctl,
  input  wire logic             own_valid,
  input  wire spq_pkg::entry_t  new_entry,
  input  wire logic             left_keep,
  input  wire spq_pkg::entry_t  left_entry,
  input  wire spq_pkg::entry_t  right_entry,
  output logic                  keep,
  output spq_pkg::entry_t       entry
);
  import spq_pkg::*;

  entry_t entry_r;
  entry_t entry_nxt;

  // An occupied cell whose priority is not above the new one stays put, so
  // equal priorities keep their arrival order.
  assign keep  = own_valid && ($signed(entry_r.prio) <= $signed(new_entry.prio));
  assign entry = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !keep) begin
      entry_nxt = left_keep ? new_entry : left_entry;
    end else if (ctl.rem) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

[tb/sv/tb_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and remove beats with random gaps and result-side stalls,
// predicts every result from a sorted list held here, and checks each
// result beat in order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1825;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_EVERY  = 400;

  typedef struct {
    logic                     operation;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    bit                       drain_first;
  } request_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [OCC_W-1:0]         occupancy;
  } outcome_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  sorted_priority_queue uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [DATA_W-1:0] held_value [CAPACITY];
  logic signed [DATA_W-1:0] held_prio  [CAPACITY];
  int                       held_count;

  request_t queued_requests [$];
  outcome_t due_outcomes    [$];
  int       total_requests;
  int       accepted_requests;
  int       error_count;
  bit       in_beat_taken;
  int       src_gap;
  int       snk_gap;

  function automatic outcome_t next_outcome(logic op, logic signed [DATA_W-1:0] v,
                                            logic signed [DATA_W-1:0] p);
    outcome_t r;
    int       slot;
    int       i;
    r.status = STATUS_OK;
    r.value  = '0;
    r.prio   = '0;
    if (op == OP_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        slot = 0;
        while (slot < held_count && held_prio[slot] <= p) slot++;
        for (i = held_count; i > slot; i--) begin
          held_value[i] = held_value[i-1];
          held_prio[i]  = held_prio[i-1];
        end
        held_value[slot] = v;
        held_prio[slot]  = p;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STATUS_UNDERFLOW;
      end else begin
        r.value = held_value[0];
        r.prio  = held_prio[0];
        for (i = 1; i < held_count; i++) begin
          held_value[i-1] = held_value[i];
          held_prio[i-1]  = held_prio[i];
        end
        held_count--;
      end
    end
    r.occupancy = held_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_prio();
    case ($urandom_range(0, 3))
      0: begin
        return $signed($urandom_range(0, 4)) - 2;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic add_request(logic op, logic signed [DATA_W-1:0] v,
                             logic signed [DATA_W-1:0] p, bit drain);
    request_t q;
    q.operation   = op;
    q.value       = v;
    q.prio        = p;
    q.drain_first = drain;
    queued_requests.push_back(q);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  always @(negedge clk) begin : drive_requests
    request_t nxt;
    if (rst_n && (!in_ch.valid || in_beat_taken)) begin
      if (src_gap > 0) begin
        in_ch.valid <= 1'b0;
        src_gap = src_gap - 1;
      end else if (queued_requests.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (queued_requests[0].drain_first && due_outcomes.size() != 0) begin
        in_ch.valid <= 1'b0;
      end else if (queued_requests.size() > CALM_TAIL && $urandom_range(0, 15) == 0) begin
        in_ch.valid <= 1'b0;
        src_gap = $urandom_range(1, 12) - 1;
      end else begin
        nxt = queued_requests.pop_front();
        in_ch.operation     <= nxt.operation;
        in_ch.item_value    <= nxt.value;
        in_ch.item_priority <= nxt.prio;
        in_ch.valid         <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (snk_gap > 0) begin
      out_ch.ready <= 1'b0;
      snk_gap = snk_gap - 1;
    end else if (queued_requests.size() > CALM_TAIL && $urandom_range(0, 11) == 0) begin
      out_ch.ready <= 1'b0;
      snk_gap = $urandom_range(1, 12) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    outcome_t got;
    in_beat_taken = rst_n && in_ch.valid && in_ch.ready;
    if (in_beat_taken) begin
      due_outcomes.push_back(next_outcome(in_ch.operation, in_ch.item_value,
                                          in_ch.item_priority));
      accepted_requests++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status    = out_ch.status;
      got.value     = out_ch.removed_value;
      got.prio      = out_ch.removed_priority;
      got.occupancy = out_ch.occupancy;
      if (due_outcomes.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d value %0d prio %0d occ %0d",
                 $time, got.status, got.value, got.prio, got.occupancy);
        error_count++;
      end else begin
        want = due_outcomes.pop_front();
        if (got.status !== want.status || got.value !== want.value ||
            got.prio !== want.prio || got.occupancy !== want.occupancy) begin
          $display("%0t: mismatch expected status %0d value %0d prio %0d occ %0d,",
                   $time, want.status, want.value, want.prio, want.occupancy,
                   " got status %0d value %0d prio %0d occ %0d",
                   got.status, got.value, got.prio, got.occupancy);
          error_count++;
        end
      end
    end
  end

  initial begin : run
    int n;
    int k;
    int seg_len;
    int bias;
    logic op;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.operation     = OP_INSERT;
    in_ch.item_value    = '0;
    in_ch.item_priority = '0;
    out_ch.ready        = 1'b0;
    held_count          = 0;
    accepted_requests   = 0;
    error_count         = 0;
    in_beat_taken       = 1'b0;
    src_gap             = 0;
    snk_gap             = 0;

    // Empty queue first, then fill it with ties and extremes, overfill it
    // once and take a few entries back out.
    add_request(OP_REMOVE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    add_request(OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    add_request(OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    add_request(OP_INSERT, 32'sd0, 32'sd0, 1'b0);
    add_request(OP_INSERT, 32'sd1, 32'sd0, 1'b0);
    add_request(OP_INSERT, -32'sd1, -32'sd1, 1'b0);
    add_request(OP_INSERT, 32'sd2, 32'sd0, 1'b0);
    add_request(OP_INSERT, 32'shAAAA_AAAA, 32'sh7FFF_FFFF, 1'b0);
    add_request(OP_INSERT, 32'sh5555_5555, 32'sh8000_0000, 1'b0);
    for (k = 0; k < 8; k++) add_request(OP_INSERT, $urandom, pick_prio(), 1'b0);
    add_request(OP_INSERT, $urandom, pick_prio(), 1'b0);
    for (k = 0; k < 7; k++) add_request(OP_REMOVE, $urandom, $urandom, 1'b0);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0: bias = 85;
        1: bias = 50;
        default: bias = 15;
      endcase
      for (k = 0; k < seg_len && n < RANDOM_ITEMS; k++) begin
        op = ($urandom_range(0, 99) < bias) ? OP_INSERT : OP_REMOVE;
        add_request(op, $urandom, (op == OP_INSERT) ? pick_prio() : $urandom,
                    (n % DRAIN_EVERY) == 0);
        n++;
      end
    end
    total_requests = queued_requests.size();

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_requests < total_requests || due_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && due_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
